// ----- rtl/tdmc_pkg.sv -----
// ----------------------------------------------------------------------------
// tdmc_pkg
// Shared types, constants and helper functions for the tube display mode
// controller: transaction structs, mode codes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tdmc_pkg;

  // Geometry and widths
  localparam int unsigned NumTubes  = 8;
  localparam int unsigned TubeIdxW  = 3;
  localparam int unsigned CodeW     = 4;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned IntervalW = 8;
  localparam int unsigned SeedW     = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned DivCntW   = 4;

  // Tube codes
  localparam logic [CodeW-1:0] CODE_COMMA = 4'd10;
  localparam logic [CodeW-1:0] CODE_BLANK = 4'd11;

  // Reset values and masks
  localparam logic [SeedW-1:0]     SEED_RESET     = 32'hd896_1d92;
  localparam logic [IntervalW-1:0] INTERVAL_RESET = 8'd5;
  localparam logic [NumTubes-1:0]  FROZEN_START   = 8'h02;
  localparam logic [NumTubes-1:0]  FROZEN_ALL     = 8'hFF;

  // Display modes
  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_WAIT     = 3'd1,
    MODE_TIME     = 3'd2,
    MODE_RANDOM   = 3'd3,
    MODE_CONVERGE = 3'd4,
    MODE_ROLL     = 3'd5
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RANDOM_SEED       = 2'd0,
    CFG_CONVERGE_INTERVAL = 2'd1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_MOD,
    ST_FREEZE,
    ST_STEP,
    ST_CFIN,
    ST_DONE
  } ctrl_state_e;

  // Input transaction
  typedef struct packed {
    logic       change_mode;
    logic       power_toggle;
    logic       turn_off;
    logic       turn_on;
    logic       time_synced;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [CodeW-1:0] tube_0;
    logic [CodeW-1:0] tube_1;
    logic [CodeW-1:0] tube_2;
    logic [CodeW-1:0] tube_3;
    logic [CodeW-1:0] tube_4;
    logic [CodeW-1:0] tube_5;
    logic [CodeW-1:0] tube_6;
    logic [CodeW-1:0] tube_7;
    logic [2:0]       mode;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic tick;
    logic div_step;
    logic freeze;
    logic tube_step;
    logic conv_finish;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    mode_e mode;
    logic  converged;
    logic  div_last;
    logic  tube_last;
  } dp_status_t;

  // One xorshift32 step (13, 17, 5)
  function automatic logic [SeedW-1:0] xorshift32(input logic [SeedW-1:0] x);
    logic [SeedW-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // x mod 10: nibble sum gives x mod 5 (16 = 1 mod 5), parity picks r or r+5
  function automatic logic [CodeW-1:0] mod10_32(input logic [SeedW-1:0] x);
    logic [6:0]  sum;
    logic [14:0] prod;
    logic [4:0]  q5;
    logic [6:0]  diff;
    logic [2:0]  r5;
    sum = 7'd0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, x[4*i +: 4]};
    end
    prod = {8'd0, sum} * 15'd205;
    q5   = prod[14:10];
    diff = sum - (({2'b00, q5} << 2) + {2'b00, q5});
    r5   = diff[2:0];
    if (r5[0] == x[0]) begin
      return {1'b0, r5};
    end else begin
      return {1'b0, r5} + 4'd5;
    end
  endfunction

  // Split a value below 64 into tens (upper nibble) and units (lower nibble)
  function automatic logic [7:0] split_decimal(input logic [5:0] v);
    logic [9:0] prod;
    logic [2:0] tens;
    logic [6:0] tens_x10;
    logic [6:0] units;
    prod     = {4'd0, v} * 10'd13;
    tens     = prod[9:7];
    tens_x10 = ({4'd0, tens} << 3) + ({4'd0, tens} << 1);
    units    = {1'b0, v} - tens_x10;
    return {1'b0, tens, units[3:0]};
  endfunction

endpackage

// ----- rtl/tdmc_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdmc_ctrl
// Sequencer for one display tick: event handling, tick dispatch, the serial
// remainder pass and the per-tube generator steps, then hand-off to the
// output register.
// ----------------------------------------------------------------------------
module tdmc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  tdmc_pkg::dp_status_t  status_i,
  output tdmc_pkg::dp_cmd_t     cmd_o
);
  import tdmc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_TICK;
      end
      ST_TICK: begin
        if (status_i.mode == MODE_RANDOM) begin
          state_d = ST_STEP;
        end else if (status_i.mode == MODE_CONVERGE && !status_i.converged) begin
          state_d = ST_MOD;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MOD: begin
        if (status_i.div_last) state_d = ST_FREEZE;
      end
      ST_FREEZE: state_d = ST_STEP;
      ST_STEP: begin
        if (status_i.tube_last) begin
          state_d = (status_i.mode == MODE_CONVERGE) ? ST_CFIN : ST_DONE;
        end
      end
      ST_CFIN: state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o             = '0;
    cmd_o.accept      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.tick        = (state_q == ST_TICK);
    cmd_o.div_step    = (state_q == ST_MOD);
    cmd_o.freeze      = (state_q == ST_FREEZE);
    cmd_o.tube_step   = (state_q == ST_STEP);
    cmd_o.conv_finish = (state_q == ST_CFIN);
    cmd_o.load_out    = (state_q == ST_DONE) && slot_free;
    in_ready_o        = (state_q == ST_IDLE);
    out_valid_o       = out_valid_q;
  end

  // Result slot occupancy
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/tdmc_datapath.sv -----
// ----------------------------------------------------------------------------
// tdmc_datapath
// Mode and effect state, the xorshift32 generator, the serial remainder unit
// for the freeze interval, the tube code registers and the result register.
// ----------------------------------------------------------------------------
module tdmc_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdmc_pkg::in_item_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [tdmc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tdmc_pkg::SeedW-1:0]        cfg_data_i,
  input  tdmc_pkg::dp_cmd_t                 cmd_i,
  output tdmc_pkg::dp_status_t              status_o,
  output tdmc_pkg::out_item_t               out_data_o
);
  import tdmc_pkg::*;

  mode_e                mode_q, mode_d;
  logic [2:0]           dot_q, dot_d;
  logic [7:0]           roll_cnt_q, roll_cnt_d;
  logic [CodeW-1:0]     roll_dig_q, roll_dig_d;
  logic [SeedW-1:0]     rng_q, rng_d;
  logic [IntervalW-1:0] iv_q, iv_d;
  logic [TicksW-1:0]    ticks_q, ticks_d;
  logic [NumTubes-1:0]  mask_q, mask_d;
  logic [TubeIdxW-1:0]  next_q, next_d;
  logic                 conv_q, conv_d;
  logic [CodeW-1:0]     tube_q [NumTubes];
  logic [CodeW-1:0]     tube_d [NumTubes];
  logic [IntervalW-1:0] rem_q, rem_d;
  logic [DivCntW-1:0]   div_cnt_q, div_cnt_d;
  logic [TubeIdxW-1:0]  idx_q, idx_d;
  logic [4:0]           hour_q;
  logic [5:0]           min_q, sec_q;
  out_item_t            out_q, out_d;

  logic [IntervalW-1:0] iv_eff;
  logic [IntervalW:0]   rem_shift;
  logic [SeedW-1:0]     rng_next;
  logic [7:0]           hh_split, mm_split, ss_split;
  mode_e                ev_mode;
  logic                 ev_start;

  assign iv_eff    = (iv_q == '0) ? IntervalW'(1) : iv_q;
  assign rem_shift = {rem_q, ticks_q[div_cnt_q]};
  assign rng_next  = xorshift32(rng_q);
  assign hh_split  = split_decimal({1'b0, hour_q});
  assign mm_split  = split_decimal(min_q);
  assign ss_split  = split_decimal(sec_q);

  // Event flags in order: mode change, power, off, on, synced
  always_comb begin
    ev_mode  = mode_q;
    ev_start = 1'b0;
    if (in_data_i.change_mode) begin
      if (mode_q == MODE_CONVERGE && conv_q) begin
        ev_start = 1'b1;
      end else if (mode_q != MODE_OFF) begin
        ev_mode  = (mode_q == MODE_ROLL) ? MODE_TIME : mode_e'(mode_q + 3'd1);
        ev_start = (ev_mode == MODE_CONVERGE);
      end
    end
    if (in_data_i.power_toggle) begin
      ev_mode = (ev_mode != MODE_OFF) ? MODE_OFF : MODE_TIME;
    end
    if (in_data_i.turn_off) ev_mode = MODE_OFF;
    if (in_data_i.turn_on && ev_mode == MODE_OFF) ev_mode = MODE_TIME;
    if (in_data_i.time_synced && ev_mode == MODE_WAIT) ev_mode = MODE_TIME;
  end

  // Next-state logic for all effect state
  always_comb begin
    mode_d     = mode_q;
    dot_d      = dot_q;
    roll_cnt_d = roll_cnt_q;
    roll_dig_d = roll_dig_q;
    rng_d      = rng_q;
    iv_d       = iv_q;
    ticks_d    = ticks_q;
    mask_d     = mask_q;
    next_d     = next_q;
    conv_d     = conv_q;
    tube_d     = tube_q;
    rem_d      = rem_q;
    div_cnt_d  = div_cnt_q;
    idx_d      = idx_q;
    out_d      = out_q;

    // Event handling on acceptance
    if (cmd_i.accept) begin
      mode_d = ev_mode;
      if (ev_start) begin
        conv_d    = 1'b0;
        ticks_d   = '0;
        next_d    = '0;
        mask_d    = FROZEN_START;
        tube_d[1] = CODE_COMMA;
      end
    end

    // Display tick dispatch
    if (cmd_i.tick) begin
      rem_d     = '0;
      div_cnt_d = DivCntW'(TicksW - 1);
      idx_d     = '0;
      unique case (mode_q)
        MODE_OFF: begin
          for (int t = 0; t < NumTubes; t++) tube_d[t] = CODE_BLANK;
        end
        MODE_WAIT: begin
          for (int t = 0; t < NumTubes; t++) begin
            tube_d[t] = (TubeIdxW'(t) == dot_q) ? CODE_COMMA : CODE_BLANK;
          end
          dot_d = dot_q + 3'd1;
        end
        MODE_TIME: begin
          tube_d[0] = hh_split[7:4];
          tube_d[1] = hh_split[3:0];
          tube_d[2] = CODE_COMMA;
          tube_d[3] = mm_split[7:4];
          tube_d[4] = mm_split[3:0];
          tube_d[5] = CODE_COMMA;
          tube_d[6] = ss_split[7:4];
          tube_d[7] = ss_split[3:0];
        end
        MODE_ROLL: begin
          for (int t = 0; t < NumTubes; t++) tube_d[t] = roll_dig_q;
          roll_cnt_d = roll_cnt_q + 8'd1;
          // digit tracks roll_count mod 10, including the 255 -> 0 wrap
          if (roll_cnt_q == 8'hFF || roll_dig_q == 4'd9) begin
            roll_dig_d = 4'd0;
          end else begin
            roll_dig_d = roll_dig_q + 4'd1;
          end
        end
        default: ;
      endcase
    end

    // Restoring remainder: converge_ticks mod interval, MSB first
    if (cmd_i.div_step) begin
      if (rem_shift >= {1'b0, iv_eff}) begin
        rem_d = IntervalW'(rem_shift - {1'b0, iv_eff});
      end else begin
        rem_d = rem_shift[IntervalW-1:0];
      end
      div_cnt_d = div_cnt_q - DivCntW'(1);
    end

    // Freeze the next tube on a nonzero multiple of the interval
    if (cmd_i.freeze) begin
      if (ticks_q != '0 && rem_q == '0) begin
        mask_d = mask_q | (NumTubes'(1) << next_q);
        next_d = next_q + TubeIdxW'(1);
      end
    end

    // One generator step per tube in random mode, per unfrozen tube when converging
    if (cmd_i.tube_step) begin
      if (mode_q == MODE_RANDOM || !mask_q[idx_q]) begin
        tube_d[idx_q] = mod10_32(rng_next);
        rng_d         = rng_next;
      end
      idx_d = idx_q + TubeIdxW'(1);
    end

    // End of a converging tick
    if (cmd_i.conv_finish) begin
      if (mask_q == FROZEN_ALL) begin
        conv_d = 1'b1;
        next_d = '0;
      end
      ticks_d = ticks_q + TicksW'(1);
    end

    // Result register
    if (cmd_i.load_out) begin
      out_d.tube_0 = tube_q[0];
      out_d.tube_1 = tube_q[1];
      out_d.tube_2 = tube_q[2];
      out_d.tube_3 = tube_q[3];
      out_d.tube_4 = tube_q[4];
      out_d.tube_5 = tube_q[5];
      out_d.tube_6 = tube_q[6];
      out_d.tube_7 = tube_q[7];
      out_d.mode   = mode_q;
    end

    // Configuration writes; a seed write reloads the generator
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RANDOM_SEED:       rng_d = cfg_data_i;
        CFG_CONVERGE_INTERVAL: iv_d  = cfg_data_i[IntervalW-1:0];
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_WAIT;
      dot_q      <= '0;
      roll_cnt_q <= '0;
      roll_dig_q <= '0;
      rng_q      <= SEED_RESET;
      iv_q       <= INTERVAL_RESET;
      ticks_q    <= '0;
      mask_q     <= '0;
      next_q     <= '0;
      conv_q     <= 1'b0;
      for (int t = 0; t < NumTubes; t++) tube_q[t] <= CODE_BLANK;
      rem_q      <= '0;
      div_cnt_q  <= '0;
      idx_q      <= '0;
    end else begin
      mode_q     <= mode_d;
      dot_q      <= dot_d;
      roll_cnt_q <= roll_cnt_d;
      roll_dig_q <= roll_dig_d;
      rng_q      <= rng_d;
      iv_q       <= iv_d;
      ticks_q    <= ticks_d;
      mask_q     <= mask_d;
      next_q     <= next_d;
      conv_q     <= conv_d;
      tube_q     <= tube_d;
      rem_q      <= rem_d;
      div_cnt_q  <= div_cnt_d;
      idx_q      <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      hour_q <= in_data_i.hour;
      min_q  <= in_data_i.minute;
      sec_q  <= in_data_i.second;
    end
    out_q <= out_d;
  end

  assign status_o.mode      = mode_q;
  assign status_o.converged = conv_q;
  assign status_o.div_last  = (div_cnt_q == '0);
  assign status_o.tube_last = (idx_q == TubeIdxW'(NumTubes - 1));
  assign out_data_o         = out_q;

endmodule

// ----- rtl/tube_display_mode_controller_core.sv -----
// ----------------------------------------------------------------------------
// tube_display_mode_controller_core
// Eight-tube display mode controller: one display tick per input transaction,
// one set of tube codes plus the mode per result transaction.
// ----------------------------------------------------------------------------
// In off, waiting, time and roll modes and in a converged effect, an input
// transaction goes from tick dispatch straight to the output hand-off; random
// mode adds one xorshift32 step per tube through the single generator, and a
// running converging effect a bit-serial remainder of the 16-bit tick count by
// the interval, a freeze step, eight tube steps and a closing step. A new
// transaction is taken while the previous result still waits in the output
// register. Configuration writes are always accepted and must only be issued
// while the block is idle; a seed write also reloads the generator.
module tube_display_mode_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tdmc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output tdmc_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdmc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tdmc_pkg::SeedW-1:0]    cfg_data_i
);
  import tdmc_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  // Sequencer
  tdmc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Datapath
  tdmc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  // One transaction in flight: acceptance drops ready
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a transaction is in flight");

  // Loading the result register raises output valid
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load_out |=> out_valid_o)
    else $error("result loaded but not presented");

  // Reported mode is a legal mode
  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.mode <= 3'(MODE_ROLL)))
    else $error("illegal mode in result");

  // Tube codes stay within digit, comma and blank
  a_codes_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.tube_0 <= CODE_BLANK && out_data_o.tube_1 <= CODE_BLANK &&
                     out_data_o.tube_2 <= CODE_BLANK && out_data_o.tube_3 <= CODE_BLANK &&
                     out_data_o.tube_4 <= CODE_BLANK && out_data_o.tube_5 <= CODE_BLANK &&
                     out_data_o.tube_6 <= CODE_BLANK && out_data_o.tube_7 <= CODE_BLANK))
    else $error("illegal tube code in result");
`endif

endmodule

// ----- tb/tb_tube_display_mode_controller_core.sv -----
// ----------------------------------------------------------------------------
// tb_tube_display_mode_controller_core
// Self-checking bench for the tube display mode controller. A behavioural
// model of the event flags, mode rotation and display tick predicts the tube
// codes and mode of every result transaction. Results are checked in order.
// A short directed run covers each mode and event, then random episodes steer
// the block through all modes under three idling profiles and several
// seed and interval settings.
// ----------------------------------------------------------------------------
module tb_tube_display_mode_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tdmc_pkg::*;

  localparam int unsigned MaxQuietCycles  = 4000;
  localparam int unsigned DrainCycles     = 64;
  localparam int unsigned MaxReported     = 10;
  localparam logic [31:0] SeedAtReset     = 32'hd896_1d92;
  localparam logic [7:0]  IntervalAtReset = 8'd5;

  // Event flag selectors for building input transactions
  localparam logic [4:0] EV_NONE   = 5'b00000;
  localparam logic [4:0] EV_CHANGE = 5'b10000;
  localparam logic [4:0] EV_POWER  = 5'b01000;
  localparam logic [4:0] EV_OFF    = 5'b00100;
  localparam logic [4:0] EV_ON     = 5'b00010;
  localparam logic [4:0] EV_SYNC   = 5'b00001;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [SeedW-1:0]    cfg_data_i  = '0;

  // Display model state
  mode_e       disp_mode;
  logic [2:0]  dot_pos;
  logic [7:0]  roll_cnt;
  logic [31:0] gen_state;
  logic [15:0] conv_ticks;
  logic [7:0]  frozen_mask;
  logic [2:0]  freeze_next;
  logic        conv_done;
  logic [3:0]  tube_code [NumTubes];
  logic [7:0]  interval_reg;

  out_item_t   expected_frames [$];
  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  tube_display_mode_controller_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Display model
  // ---------------------------------------------------------------------------
  function automatic void reset_display_model();
    disp_mode    = MODE_WAIT;
    dot_pos      = '0;
    roll_cnt     = '0;
    gen_state    = SeedAtReset;
    conv_ticks   = '0;
    frozen_mask  = '0;
    freeze_next  = '0;
    conv_done    = 1'b0;
    interval_reg = IntervalAtReset;
    for (int t = 0; t < NumTubes; t++) tube_code[t] = CODE_BLANK;
  endfunction

  // xorshift32 step, digit is the new state mod 10
  function automatic logic [3:0] next_random_digit();
    logic [31:0] x;
    x = gen_state;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    gen_state = x;
    return 4'(x % 32'd10);
  endfunction

  function automatic void restart_converge();
    conv_done    = 1'b0;
    conv_ticks   = '0;
    freeze_next  = '0;
    frozen_mask  = 8'h02;
    tube_code[1] = CODE_COMMA;
  endfunction

  function automatic void converge_tick_model();
    logic [7:0] step;
    step = (interval_reg == 8'd0) ? 8'd1 : interval_reg;
    if (conv_done) return;
    // freeze the next tube every interval ticks
    if (conv_ticks != 16'd0 && (conv_ticks % step) == 16'd0) begin
      frozen_mask[freeze_next] = 1'b1;
      freeze_next = freeze_next + 3'd1;
    end
    for (int t = 0; t < NumTubes; t++) begin
      if (!frozen_mask[t]) tube_code[t] = next_random_digit();
    end
    if (frozen_mask == 8'hFF) begin
      conv_done   = 1'b1;
      freeze_next = '0;
    end
    conv_ticks = conv_ticks + 16'd1;
  endfunction

  function automatic out_item_t predict_display_tick(in_item_t it);
    out_item_t res;
    // event flags in their fixed order
    if (it.change_mode) begin
      if (disp_mode == MODE_CONVERGE && conv_done) begin
        restart_converge();
      end else begin
        case (disp_mode)
          MODE_WAIT:     disp_mode = MODE_TIME;
          MODE_TIME:     disp_mode = MODE_RANDOM;
          MODE_RANDOM: begin
            disp_mode = MODE_CONVERGE;
            restart_converge();
          end
          MODE_CONVERGE: disp_mode = MODE_ROLL;
          MODE_ROLL:     disp_mode = MODE_TIME;
          default:       ;
        endcase
      end
    end
    if (it.power_toggle) disp_mode = (disp_mode != MODE_OFF) ? MODE_OFF : MODE_TIME;
    if (it.turn_off) disp_mode = MODE_OFF;
    if (it.turn_on && disp_mode == MODE_OFF) disp_mode = MODE_TIME;
    if (it.time_synced && disp_mode == MODE_WAIT) disp_mode = MODE_TIME;

    // display tick
    case (disp_mode)
      MODE_OFF: begin
        for (int t = 0; t < NumTubes; t++) tube_code[t] = CODE_BLANK;
      end
      MODE_WAIT: begin
        for (int t = 0; t < NumTubes; t++) begin
          tube_code[t] = (t == dot_pos) ? CODE_COMMA : CODE_BLANK;
        end
        dot_pos = dot_pos + 3'd1;
      end
      MODE_TIME: begin
        tube_code[0] = 4'(it.hour / 10);
        tube_code[1] = 4'(it.hour % 10);
        tube_code[2] = CODE_COMMA;
        tube_code[3] = 4'(it.minute / 10);
        tube_code[4] = 4'(it.minute % 10);
        tube_code[5] = CODE_COMMA;
        tube_code[6] = 4'(it.second / 10);
        tube_code[7] = 4'(it.second % 10);
      end
      MODE_RANDOM: begin
        for (int t = 0; t < NumTubes; t++) tube_code[t] = next_random_digit();
      end
      MODE_CONVERGE: converge_tick_model();
      MODE_ROLL: begin
        for (int t = 0; t < NumTubes; t++) tube_code[t] = 4'(roll_cnt % 8'd10);
        roll_cnt = roll_cnt + 8'd1;
      end
      default: ;
    endcase

    res.tube_0 = tube_code[0];
    res.tube_1 = tube_code[1];
    res.tube_2 = tube_code[2];
    res.tube_3 = tube_code[3];
    res.tube_4 = tube_code[4];
    res.tube_5 = tube_code[5];
    res.tube_6 = tube_code[6];
    res.tube_7 = tube_code[7];
    res.mode   = disp_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly legal clock time, now and then the full field width
  function automatic in_item_t make_item(logic [4:0] ev);
    in_item_t it;
    {it.change_mode, it.power_toggle, it.turn_off, it.turn_on, it.time_synced} = ev;
    if ($urandom_range(7) == 0) begin
      it.hour   = 5'($urandom);
      it.minute = 6'($urandom);
      it.second = 6'($urandom);
    end else begin
      it.hour   = 5'($urandom_range(23));
      it.minute = 6'($urandom_range(59));
      it.second = 6'($urandom_range(59));
    end
    return it;
  endfunction

  // One step from the current model mode towards the wanted one
  function automatic in_item_t steer_towards(mode_e target);
    logic coin;
    coin = 1'($urandom);
    if (disp_mode == target) return make_item(EV_NONE);
    if (target == MODE_OFF) return make_item(coin ? EV_OFF : EV_POWER);
    if (disp_mode == MODE_OFF) return make_item(coin ? EV_ON : EV_POWER);
    if (disp_mode == MODE_WAIT) return make_item(coin ? EV_SYNC : EV_CHANGE);
    // a converged effect would only restart on a mode change
    if (disp_mode == MODE_CONVERGE && conv_done) return make_item(EV_POWER);
    return make_item(EV_CHANGE);
  endfunction

  // Send one transaction; valid is left high for a back-to-back follower
  task automatic send_tick(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_frames.push_back(predict_display_tick(it));
    items_sent++;
    @(negedge clk_i);
  endtask

  // Stop sending, let every result come back, then let the block settle
  task automatic wait_until_drained();
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [31:0] value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_RANDOM_SEED) gen_state = value;
    else interval_reg = value[7:0];
    @(negedge clk_i);
  endtask

  // Upper bits of the interval write are don't-care and get random content
  task automatic configure(input logic [31:0] seed, input logic [7:0] interval);
    write_register(CFG_RANDOM_SEED, seed);
    write_register(CFG_CONVERGE_INTERVAL, {24'($urandom), interval});
    cfg_valid_i = 1'b0;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: waiting dot walk, time extremes, every event and rotation
  task automatic test_mode_sequencing();
    in_item_t it;
    repeat (9) send_tick(make_item(EV_NONE));
    it = make_item(EV_SYNC);
    it.hour   = 5'd31;
    it.minute = 6'd63;
    it.second = 6'd63;
    send_tick(it);
    it = make_item(EV_NONE);
    it.hour   = '0;
    it.minute = '0;
    it.second = '0;
    send_tick(it);
    it = make_item(EV_NONE);
    it.hour   = 5'd23;
    it.minute = 6'd59;
    it.second = 6'd59;
    send_tick(it);
    // time -> random -> converging -> roll -> time
    repeat (4) send_tick(make_item(EV_CHANGE));
    send_tick(make_item(EV_POWER));
    // mode change is ignored while off
    send_tick(make_item(EV_CHANGE));
    send_tick(make_item(EV_POWER));
    send_tick(make_item(EV_OFF | EV_ON));
    send_tick(make_item(EV_CHANGE | EV_POWER | EV_OFF | EV_ON | EV_SYNC));
    send_tick(make_item(EV_OFF));
    send_tick(make_item(EV_ON));
  endtask

  // Zero seed gives all-zero digits; zero interval behaves as one
  task automatic test_zero_seed_and_interval();
    wait_until_drained();
    configure(32'd0, 8'd0);
    send_tick(make_item(EV_CHANGE));
    send_tick(make_item(EV_CHANGE));
    repeat (3) send_tick(make_item(EV_NONE));
  endtask

  // Episodes: steer to a mode, dwell there, with some noise on the flags
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input logic [31:0] seed,
                                     input logic [7:0]  interval);
    int unsigned goal;
    int unsigned span;
    int unsigned pick;
    int unsigned eff_iv;
    mode_e       target;
    in_item_t    it;
    wait_until_drained();
    configure(seed, interval);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    eff_iv = (interval == 8'd0) ? 1 : interval;
    goal   = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(9);
      case (pick)
        0: begin
          target = MODE_OFF;
          span   = $urandom_range(2, 6);
        end
        1, 2: begin
          target = MODE_TIME;
          span   = $urandom_range(2, 10);
        end
        3, 4: begin
          target = MODE_RANDOM;
          span   = $urandom_range(2, 10);
        end
        5, 6: begin
          target = MODE_CONVERGE;
          span   = (eff_iv * 9 + 6 > 80) ? 80 : eff_iv * 9 + 6;
        end
        default: begin
          target = MODE_ROLL;
          span   = $urandom_range(10, 50);
        end
      endcase
      for (int k = 0; k < span && items_sent < goal; k++) begin
        if ($urandom_range(99) < 5) begin
          it = make_item(5'($urandom));
        end else begin
          it = steer_towards(target);
          // restart a finished effect now and then
          if (target == MODE_CONVERGE && disp_mode == MODE_CONVERGE && conv_done &&
              $urandom_range(3) == 0) begin
            it.change_mode = 1'b1;
          end
        end
        send_tick(it);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result receiver and checker
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (expected_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("unexpected result transaction: tubes %0d %0d %0d %0d %0d %0d %0d %0d mode %0d",
                   got.tube_0, got.tube_1, got.tube_2, got.tube_3,
                   got.tube_4, got.tube_5, got.tube_6, got.tube_7, got.mode);
        end
      end else begin
        want = expected_frames.pop_front();
        if (got.tube_0 !== want.tube_0 || got.tube_1 !== want.tube_1 ||
            got.tube_2 !== want.tube_2 || got.tube_3 !== want.tube_3 ||
            got.tube_4 !== want.tube_4 || got.tube_5 !== want.tube_5 ||
            got.tube_6 !== want.tube_6 || got.tube_7 !== want.tube_7 ||
            got.mode !== want.mode) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("mismatch: expected tubes %0d %0d %0d %0d %0d %0d %0d %0d mode %0d",
                     want.tube_0, want.tube_1, want.tube_2, want.tube_3,
                     want.tube_4, want.tube_5, want.tube_6, want.tube_7, want.mode);
            $display("          actual   tubes %0d %0d %0d %0d %0d %0d %0d %0d mode %0d",
                     got.tube_0, got.tube_1, got.tube_2, got.tube_3,
                     got.tube_4, got.tube_5, got.tube_6, got.tube_7, got.mode);
          end
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= MaxQuietCycles) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_display_model();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 10;
    recv_idle_pct = 67;
    test_mode_sequencing();
    test_zero_seed_and_interval();
    test_random_traffic(620, 10, 67, 32'd1, 8'd1);
    test_random_traffic(610, 67, 10, 32'hFFFF_FFFF, 8'd255);
    test_random_traffic(600, 0, 0, $urandom | 32'd1, 8'($urandom_range(2, 12)));

    wait_until_drained();
    if (mismatch_count == 0 && expected_frames.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
